// ----- sv/lpg_pkg.sv -----
// Package for the line pixel generator.
// Holds the function codes, the colour width and the command struct used
// between the top level and the line walker. Depends on nothing.
package lpg_pkg;

    // Width of the red, green and blue colour word.
    localparam int COLOUR_W = 24;

    // Function code carried by each input beat.
    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_STEP = 1'b1
    } t_func;

    // What the walker is told to do with the beat that is advancing.
    typedef struct packed {
        logic load;
        logic step;
    } t_walk_cmd;

endpackage

// ----- sv/line_pixel_generator.sv -----
// Line pixel generator: midpoint line rasteriser for all octants.
//
// Input channel (i_valid / o_ready): each beat carries i_func and a full set
// of line fields. A load beat (i_func = 0) stores two endpoints, a depth and
// a colour and produces no pixel; a load while a line runs replaces it.
// A step beat (i_func = 1) produces one pixel; after the loop pixels the far
// endpoint comes out with o_last high and the block goes idle. A step beat
// while idle is consumed and produces nothing. The depth is that of the
// endpoint with the smaller x and is the same on every pixel.
// Output channel (o_valid / i_ready): one beat per pixel.
// A step beat accepted sits in the input register; its pixel is then written to the
// result register, which drives the output.
// Throughput: one beat per cycle while i_ready is high; the pixel update is one
// add and one sign compare on the decision value, done between the two registers.
// Reset (i_rst_n low, synchronous) empties both registers and leaves the
// block idle with no line loaded. When the receiver holds i_ready low, the
// result register keeps its pixel and one further beat waits in the input
// register; o_ready then drops until the result is taken.
// Depends on lpg_pkg, lpg_setup and lpg_walker.
module line_pixel_generator import lpg_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_func,
    input  logic signed [COORD_BITS-1:0]   i_x_start,
    input  logic signed [COORD_BITS-1:0]   i_y_start,
    input  logic signed [DEPTH_BITS-1:0]   i_z_start,
    input  logic signed [COORD_BITS-1:0]   i_x_end,
    input  logic signed [COORD_BITS-1:0]   i_y_end,
    input  logic signed [DEPTH_BITS-1:0]   i_z_end,
    input  logic        [COLOUR_W-1:0]     i_colour,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [COORD_BITS-1:0]   o_pixel_x,
    output logic signed [COORD_BITS-1:0]   o_pixel_y,
    output logic signed [DEPTH_BITS-1:0]   o_pixel_z,
    output logic        [COLOUR_W-1:0]     o_pixel_colour,
    output logic                           o_last
);

    logic                          r_in_valid;
    t_func                         r_in_func;
    logic signed [COORD_BITS-1:0]  r_in_x_start;
    logic signed [COORD_BITS-1:0]  r_in_y_start;
    logic signed [DEPTH_BITS-1:0]  r_in_z_start;
    logic signed [COORD_BITS-1:0]  r_in_x_end;
    logic signed [COORD_BITS-1:0]  r_in_y_end;
    logic signed [DEPTH_BITS-1:0]  r_in_z_end;
    logic        [COLOUR_W-1:0]    r_in_colour;

    logic                          r_out_valid;
    logic signed [COORD_BITS-1:0]  r_out_x;
    logic signed [COORD_BITS-1:0]  r_out_y;
    logic signed [DEPTH_BITS-1:0]  r_out_z;
    logic        [COLOUR_W-1:0]    r_out_colour;
    logic                          r_out_last;

    logic signed [COORD_BITS-1:0]  su_first_x;
    logic signed [COORD_BITS-1:0]  su_first_y;
    logic signed [COORD_BITS-1:0]  su_last_x;
    logic signed [COORD_BITS-1:0]  su_last_y;
    logic signed [DEPTH_BITS-1:0]  su_depth;
    logic signed [COORD_BITS+1:0]  su_twice_dy;
    logic signed [COORD_BITS+1:0]  su_cross_inc;
    logic signed [COORD_BITS+2:0]  su_diag_inc;
    logic signed [COORD_BITS+3:0]  su_decision;
    logic        [COORD_BITS-1:0]  su_steps;
    logic                          su_is_wide;
    logic                          su_step_neg;

    logic                          walk_active;
    logic                          pix_valid;
    logic signed [COORD_BITS-1:0]  pix_x;
    logic signed [COORD_BITS-1:0]  pix_y;
    logic signed [DEPTH_BITS-1:0]  pix_z;
    logic        [COLOUR_W-1:0]    pix_colour;
    logic                          pix_last;

    logic                          is_step;
    logic                          makes_pixel;
    logic                          advance;
    t_walk_cmd                     cmd;

    // The held beat moves on unless it makes a pixel and the result
    // register is still full and stalled.
    assign is_step     = r_in_func == FUNC_STEP;
    assign makes_pixel = is_step && walk_active;
    assign advance     = r_in_valid && (!makes_pixel || !r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || advance;

    assign cmd.load = advance && !is_step;
    assign cmd.step = advance && is_step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_func    <= t_func'(i_func);
            r_in_x_start <= i_x_start;
            r_in_y_start <= i_y_start;
            r_in_z_start <= i_z_start;
            r_in_x_end   <= i_x_end;
            r_in_y_end   <= i_y_end;
            r_in_z_end   <= i_z_end;
            r_in_colour  <= i_colour;
        end
    end

    lpg_setup #(
        .COORD_BITS (COORD_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_setup (
        .i_x_start   (r_in_x_start),
        .i_y_start   (r_in_y_start),
        .i_z_start   (r_in_z_start),
        .i_x_end     (r_in_x_end),
        .i_y_end     (r_in_y_end),
        .i_z_end     (r_in_z_end),
        .o_first_x   (su_first_x),
        .o_first_y   (su_first_y),
        .o_last_x    (su_last_x),
        .o_last_y    (su_last_y),
        .o_depth     (su_depth),
        .o_twice_dy  (su_twice_dy),
        .o_cross_inc (su_cross_inc),
        .o_diag_inc  (su_diag_inc),
        .o_decision  (su_decision),
        .o_steps     (su_steps),
        .o_is_wide   (su_is_wide),
        .o_step_neg  (su_step_neg)
    );

    lpg_walker #(
        .COORD_BITS (COORD_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_first_x    (su_first_x),
        .i_first_y    (su_first_y),
        .i_last_x     (su_last_x),
        .i_last_y     (su_last_y),
        .i_depth      (su_depth),
        .i_colour     (r_in_colour),
        .i_twice_dy   (su_twice_dy),
        .i_cross_inc  (su_cross_inc),
        .i_diag_inc   (su_diag_inc),
        .i_decision   (su_decision),
        .i_steps      (su_steps),
        .i_is_wide    (su_is_wide),
        .i_step_neg   (su_step_neg),
        .o_active     (walk_active),
        .o_pix_valid  (pix_valid),
        .o_pix_x      (pix_x),
        .o_pix_y      (pix_y),
        .o_pix_z      (pix_z),
        .o_pix_colour (pix_colour),
        .o_pix_last   (pix_last)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pix_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_valid) begin
            r_out_x      <= pix_x;
            r_out_y      <= pix_y;
            r_out_z      <= pix_z;
            r_out_colour <= pix_colour;
            r_out_last   <= pix_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_x      = r_out_x;
    assign o_pixel_y      = r_out_y;
    assign o_pixel_z      = r_out_z;
    assign o_pixel_colour = r_out_colour;
    assign o_last         = r_out_last;

endmodule

// ----- sv/lpg_setup.sv -----
// Line set-up logic: orders the endpoints and works out the initial
// decision value, step count and increments of a new line.
// Depends on lpg_pkg.
module lpg_setup import lpg_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 32
) (
    input  logic signed [COORD_BITS-1:0]   i_x_start,
    input  logic signed [COORD_BITS-1:0]   i_y_start,
    input  logic signed [DEPTH_BITS-1:0]   i_z_start,
    input  logic signed [COORD_BITS-1:0]   i_x_end,
    input  logic signed [COORD_BITS-1:0]   i_y_end,
    input  logic signed [DEPTH_BITS-1:0]   i_z_end,
    output logic signed [COORD_BITS-1:0]   o_first_x,
    output logic signed [COORD_BITS-1:0]   o_first_y,
    output logic signed [COORD_BITS-1:0]   o_last_x,
    output logic signed [COORD_BITS-1:0]   o_last_y,
    output logic signed [DEPTH_BITS-1:0]   o_depth,
    output logic signed [COORD_BITS+1:0]   o_twice_dy,
    output logic signed [COORD_BITS+1:0]   o_cross_inc,
    output logic signed [COORD_BITS+2:0]   o_diag_inc,
    output logic signed [COORD_BITS+3:0]   o_decision,
    output logic        [COORD_BITS-1:0]   o_steps,
    output logic                           o_is_wide,
    output logic                           o_step_neg
);

    localparam int DX_W  = COORD_BITS + 1;
    localparam int TW_W  = COORD_BITS + 2;
    localparam int DG_W  = COORD_BITS + 3;
    localparam int DEC_W = COORD_BITS + 4;

    logic                      swap;
    logic signed [DX_W-1:0]    dx;
    logic signed [DX_W-1:0]    dy;
    logic signed [DX_W-1:0]    abs_dy;
    logic signed [TW_W-1:0]    neg_twice_dx;
    logic signed [DEC_W-1:0]   dx_term;

    // Walk always runs from the endpoint with the smaller x.
    assign swap      = i_x_start > i_x_end;
    assign o_first_x = swap ? i_x_end   : i_x_start;
    assign o_first_y = swap ? i_y_end   : i_y_start;
    assign o_last_x  = swap ? i_x_start : i_x_end;
    assign o_last_y  = swap ? i_y_start : i_y_end;
    assign o_depth   = swap ? i_z_end   : i_z_start;

    // Deltas; dx is never negative after the swap.
    assign dx     = DX_W'(o_last_x) - DX_W'(o_first_x);
    assign dy     = DX_W'(o_last_y) - DX_W'(o_first_y);
    assign abs_dy = dy[DX_W-1] ? -dy : dy;

    assign o_twice_dy   = $signed({dy, 1'b0});
    assign neg_twice_dx = -$signed({dx, 1'b0});
    assign o_step_neg   = !(dy > DX_W'(0));
    assign o_is_wide    = dx >= abs_dy;

    // Cross-axis increment is the step direction times minus twice dx.
    assign o_cross_inc = o_step_neg ? -neg_twice_dx : neg_twice_dx;
    assign o_diag_inc  = DG_W'(o_twice_dy) + DG_W'(o_cross_inc);

    // Initial decision value for each of the two major axes.
    assign dx_term = o_step_neg ? DEC_W'(dx) : -DEC_W'(dx);

    always_comb begin
        if (o_is_wide) begin
            o_decision = DEC_W'(o_twice_dy) + dx_term;
            o_steps    = dx[COORD_BITS-1:0];
        end else begin
            o_decision = DEC_W'(dy) + DEC_W'(o_cross_inc);
            o_steps    = abs_dy[COORD_BITS-1:0];
        end
    end

endmodule

// ----- sv/lpg_walker.sv -----
// Line walker: holds the state of the running line and produces one pixel
// for each step command while a line runs, with a single add-and-compare update.
// Depends on lpg_pkg and on values computed by lpg_setup.
module lpg_walker import lpg_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_walk_cmd                      i_cmd,
    input  logic signed [COORD_BITS-1:0]   i_first_x,
    input  logic signed [COORD_BITS-1:0]   i_first_y,
    input  logic signed [COORD_BITS-1:0]   i_last_x,
    input  logic signed [COORD_BITS-1:0]   i_last_y,
    input  logic signed [DEPTH_BITS-1:0]   i_depth,
    input  logic        [COLOUR_W-1:0]     i_colour,
    input  logic signed [COORD_BITS+1:0]   i_twice_dy,
    input  logic signed [COORD_BITS+1:0]   i_cross_inc,
    input  logic signed [COORD_BITS+2:0]   i_diag_inc,
    input  logic signed [COORD_BITS+3:0]   i_decision,
    input  logic        [COORD_BITS-1:0]   i_steps,
    input  logic                           i_is_wide,
    input  logic                           i_step_neg,
    output logic                           o_active,
    output logic                           o_pix_valid,
    output logic signed [COORD_BITS-1:0]   o_pix_x,
    output logic signed [COORD_BITS-1:0]   o_pix_y,
    output logic signed [DEPTH_BITS-1:0]   o_pix_z,
    output logic        [COLOUR_W-1:0]     o_pix_colour,
    output logic                           o_pix_last
);

    localparam int DEC_W = COORD_BITS + 4;

    logic signed [COORD_BITS-1:0]  r_cur_x,     n_cur_x;
    logic signed [COORD_BITS-1:0]  r_cur_y,     n_cur_y;
    logic signed [COORD_BITS-1:0]  r_end_x,     n_end_x;
    logic signed [COORD_BITS-1:0]  r_end_y,     n_end_y;
    logic signed [DEPTH_BITS-1:0]  r_depth,     n_depth;
    logic        [COLOUR_W-1:0]    r_colour,    n_colour;
    logic signed [COORD_BITS+1:0]  r_twice_dy,  n_twice_dy;
    logic signed [COORD_BITS+1:0]  r_cross_inc, n_cross_inc;
    logic signed [COORD_BITS+2:0]  r_diag_inc,  n_diag_inc;
    logic signed [DEC_W-1:0]       r_decision,  n_decision;
    logic        [COORD_BITS-1:0]  r_steps,     n_steps;
    logic                          r_is_wide,   n_is_wide;
    logic                          r_step_neg,  n_step_neg;
    logic                          r_active,    n_active;

    logic                          at_end;
    logic                          dy_pos;
    logic                          dy_neg;
    logic                          dec_pos;
    logic                          dec_neg;
    logic                          diag;
    logic signed [DEC_W-1:0]       dec_inc;
    logic signed [COORD_BITS-1:0]  y_next;

    // Pixel shown for a step: the loop pixel, or the far endpoint at the end.
    assign at_end       = r_steps == '0;
    assign o_active     = r_active;
    assign o_pix_valid  = i_cmd.step && r_active;
    assign o_pix_x      = at_end ? r_end_x : r_cur_x;
    assign o_pix_y      = at_end ? r_end_y : r_cur_y;
    assign o_pix_z      = r_depth;
    assign o_pix_colour = r_colour;
    assign o_pix_last   = at_end;

    // Diagonal move decision from the signs of dy and the decision value.
    assign dy_pos  = !r_step_neg;
    assign dy_neg  = r_twice_dy[COORD_BITS+1];
    assign dec_pos = r_decision > DEC_W'(0);
    assign dec_neg = r_decision[DEC_W-1];
    assign diag    = r_is_wide ? ((dy_pos && dec_pos) || (dy_neg && dec_neg))
                               : ((dy_pos && dec_neg) || (dy_neg && dec_pos));

    // Increment of the decision value for the chosen move.
    always_comb begin
        if (diag) begin
            dec_inc = DEC_W'(r_diag_inc);
        end else if (r_is_wide) begin
            dec_inc = DEC_W'(r_twice_dy);
        end else begin
            dec_inc = DEC_W'(r_cross_inc);
        end
    end

    assign y_next = r_step_neg ? r_cur_y - COORD_BITS'(1) : r_cur_y + COORD_BITS'(1);

    // Next state: a load restarts the line, a step advances it by one pixel or ends it at the far endpoint.
    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_end_x     = r_end_x;
        n_end_y     = r_end_y;
        n_depth     = r_depth;
        n_colour    = r_colour;
        n_twice_dy  = r_twice_dy;
        n_cross_inc = r_cross_inc;
        n_diag_inc  = r_diag_inc;
        n_decision  = r_decision;
        n_steps     = r_steps;
        n_is_wide   = r_is_wide;
        n_step_neg  = r_step_neg;
        n_active    = r_active;
        if (i_cmd.load) begin
            n_cur_x     = i_first_x;
            n_cur_y     = i_first_y;
            n_end_x     = i_last_x;
            n_end_y     = i_last_y;
            n_depth     = i_depth;
            n_colour    = i_colour;
            n_twice_dy  = i_twice_dy;
            n_cross_inc = i_cross_inc;
            n_diag_inc  = i_diag_inc;
            n_decision  = i_decision;
            n_steps     = i_steps;
            n_is_wide   = i_is_wide;
            n_step_neg  = i_step_neg;
            n_active    = 1'b1;
        end else if (o_pix_valid) begin
            if (at_end) begin
                n_active = 1'b0;
            end else begin
                if (diag || r_is_wide) begin
                    n_cur_x = r_cur_x + COORD_BITS'(1);
                end
                if (diag || !r_is_wide) begin
                    n_cur_y = y_next;
                end
                n_decision = r_decision + dec_inc;
                n_steps    = r_steps - COORD_BITS'(1);
            end
        end
    end

    // Only the busy flag needs a reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x     <= n_cur_x;
        r_cur_y     <= n_cur_y;
        r_end_x     <= n_end_x;
        r_end_y     <= n_end_y;
        r_depth     <= n_depth;
        r_colour    <= n_colour;
        r_twice_dy  <= n_twice_dy;
        r_cross_inc <= n_cross_inc;
        r_diag_inc  <= n_diag_inc;
        r_decision  <= n_decision;
        r_steps     <= n_steps;
        r_is_wide   <= n_is_wide;
        r_step_neg  <= n_step_neg;
    end

endmodule

// ----- sv/lpg_checker.sv -----
// Port-level checker for the line pixel generator, bound to the top level.
// Depends on lpg_pkg and line_pixel_generator.
module lpg_checker import lpg_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_ready,
    input  logic                           o_valid,
    input  logic                           i_ready,
    input  logic signed [COORD_BITS-1:0]   o_pixel_x,
    input  logic signed [COORD_BITS-1:0]   o_pixel_y,
    input  logic signed [DEPTH_BITS-1:0]   o_pixel_z,
    input  logic        [COLOUR_W-1:0]     o_pixel_colour,
    input  logic                           o_last
);

    // A pixel beat that is stalled stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("stalled pixel beat was withdrawn");

    // A stalled pixel beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_pixel_x) && $stable(o_pixel_y)
            && $stable(o_pixel_z) && $stable(o_pixel_colour) && $stable(o_last))
        else $error("stalled pixel beat changed its payload");

    // Reset empties the result register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("pixel beat offered straight after reset");

    // The input side only stalls behind a full, stalled result register.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled while the output could move");

endmodule

bind line_pixel_generator lpg_checker #(
    .COORD_BITS (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
) u_lpg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_pixel_x      (o_pixel_x),
    .o_pixel_y      (o_pixel_y),
    .o_pixel_z      (o_pixel_z),
    .o_pixel_colour (o_pixel_colour),
    .o_last         (o_last)
);

// ----- dv/testbench.sv -----
// Testbench for the line pixel generator: directed table then random lines, checked
// beat by beat against a midpoint line predictor held in this file.
// Depends on lpg_pkg and line_pixel_generator.
`timescale 1ns / 100ps

module testbench;
    import lpg_pkg::*;

    localparam int CB           = 12;
    localparam int DB           = 32;
    localparam int COORD_MAX    = 2 ** (CB - 1) - 1;
    localparam int COORD_MIN    = -(2 ** (CB - 1));
    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 450;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PERCENT = 34;

    typedef logic signed [CB-1:0] t_coord;
    typedef logic signed [DB-1:0] t_depth;

    typedef struct {
        t_func               func;
        t_coord              xs, ys, xe, ye;
        t_depth              zs, ze;
        logic [COLOUR_W-1:0] colour;
    } t_beat;

    typedef struct {
        t_coord              x, y;
        t_depth              z;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } t_pixel;

    typedef struct {
        t_beat  beat;
        bit     typed;
        t_pixel want;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_func;
    t_coord              i_x_start, i_y_start, i_x_end, i_y_end;
    t_depth              i_z_start, i_z_end;
    logic [COLOUR_W-1:0] i_colour;
    logic                o_valid;
    logic                i_ready;
    t_coord              o_pixel_x, o_pixel_y;
    t_depth              o_pixel_z;
    logic [COLOUR_W-1:0] o_pixel_colour;
    logic                o_last;

    // Shared run state.
    t_pixel pending_pixels[$];
    int     mismatches     = 0;
    int     pixels_checked = 0;
    int     ends_checked   = 0;
    int     lines_loaded   = 0;
    int     idle_steps     = 0;
    int     beats_counted  = 0;
    int     cycles         = 0;
    int     hold_asked     = 0;
    bit     idle_on;

    // Predictor copy of the line walker state.
    int                  ln_cur_x = 0, ln_cur_y = 0, ln_decision = 0, ln_steps_left = 0;
    int                  ln_end_x = 0, ln_end_y = 0, ln_twice_dy = 0, ln_neg_twice_dx = 0;
    int                  ln_step_y = 0;
    bit                  ln_wide = 1'b0, ln_active = 1'b0;
    t_depth              ln_depth = '0;
    logic [COLOUR_W-1:0] ln_colour = '0;

    line_pixel_generator #(
        .COORD_BITS (CB),
        .DEPTH_BITS (DB)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_z_start      (i_z_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_z_end        (i_z_end),
        .i_colour       (i_colour),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_z      (o_pixel_z),
        .o_pixel_colour (o_pixel_colour),
        .o_last         (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d pixels outstanding.",
                     cycles, pending_pixels.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Apply one beat to the predicted walker; returns 1 when a pixel comes out.
    function automatic bit rasterise_beat(input t_beat b, output t_pixel p);
        int     xa, ya, xb, yb, dx, dy;
        t_depth za;
        bit     diag;
        p = '{x: '0, y: '0, z: '0, colour: '0, last: 1'b0};
        if (b.func == FUNC_LOAD) begin
            xa = b.xs;
            ya = b.ys;
            xb = b.xe;
            yb = b.ye;
            za = b.zs;
            // Walk always runs towards larger x; the depth is that of the endpoint with the smaller x.
            if (xa > xb) begin
                xa = b.xe;
                ya = b.ye;
                xb = b.xs;
                yb = b.ys;
                za = b.ze;
            end
            dx = xb - xa;
            dy = yb - ya;
            ln_cur_x        = xa;
            ln_cur_y        = ya;
            ln_end_x        = xb;
            ln_end_y        = yb;
            ln_twice_dy     = 2 * dy;
            ln_neg_twice_dx = -2 * dx;
            ln_step_y       = (ln_twice_dy > 0) ? 1 : -1;
            ln_wide         = dx >= ((dy < 0) ? -dy : dy);
            if (ln_wide) begin
                ln_decision   = ln_twice_dy - ln_step_y * dx;
                ln_steps_left = dx;
            end else begin
                ln_decision   = dy + ln_step_y * ln_neg_twice_dx;
                ln_steps_left = (dy < 0) ? -dy : dy;
            end
            ln_depth  = za;
            ln_colour = b.colour;
            ln_active = 1'b1;
            return 1'b0;
        end
        if (!ln_active)
            return 1'b0;
        p.z      = ln_depth;
        p.colour = ln_colour;
        // The exact far endpoint closes the line.
        if (ln_steps_left == 0) begin
            p.x       = t_coord'(ln_end_x);
            p.y       = t_coord'(ln_end_y);
            p.last    = 1'b1;
            ln_active = 1'b0;
            return 1'b1;
        end
        p.x = t_coord'(ln_cur_x);
        p.y = t_coord'(ln_cur_y);
        if (ln_wide)
            diag = (ln_twice_dy > 0 && ln_decision > 0) || (ln_twice_dy < 0 && ln_decision < 0);
        else
            diag = (ln_twice_dy > 0 && ln_decision < 0) || (ln_twice_dy < 0 && ln_decision > 0);
        if (diag) begin
            ln_cur_x    += 1;
            ln_cur_y    += ln_step_y;
            ln_decision += ln_twice_dy + ln_step_y * ln_neg_twice_dx;
        end else if (ln_wide) begin
            ln_cur_x    += 1;
            ln_decision += ln_twice_dy;
        end else begin
            ln_cur_y    += ln_step_y;
            ln_decision += ln_step_y * ln_neg_twice_dx;
        end
        ln_steps_left -= 1;
        return 1'b1;
    endfunction

    function automatic t_beat random_beat(input t_func f);
        t_beat b;
        b.func   = f;
        b.xs     = t_coord'($urandom);
        b.ys     = t_coord'($urandom);
        b.xe     = t_coord'($urandom);
        b.ye     = t_coord'($urandom);
        b.zs     = $urandom;
        b.ze     = $urandom;
        b.colour = COLOUR_W'($urandom);
        return b;
    endfunction

    function automatic t_coord clamp_coord(input int v);
        if (v > COORD_MAX)
            return t_coord'(COORD_MAX);
        if (v < COORD_MIN)
            return t_coord'(COORD_MIN);
        return t_coord'(v);
    endfunction

    function automatic t_row load_row(input int xs, input int ys, input t_depth zs,
                                      input int xe, input int ye, input t_depth ze,
                                      input logic [COLOUR_W-1:0] col);
        t_row r;
        r.beat        = '{func: FUNC_LOAD, xs: t_coord'(xs), ys: t_coord'(ys),
                          xe: t_coord'(xe), ye: t_coord'(ye), zs: zs, ze: ze, colour: col};
        r.typed       = 1'b0;
        r.want        = '{x: '0, y: '0, z: '0, colour: '0, last: 1'b0};
        return r;
    endfunction

    // A step row; the pixel is typed in only when typed is set.
    function automatic t_row step_row(input bit typed, input int x, input int y,
                                      input t_depth z, input logic [COLOUR_W-1:0] col,
                                      input logic last);
        t_row r;
        r.beat  = random_beat(FUNC_STEP);
        r.typed = typed;
        r.want  = '{x: t_coord'(x), y: t_coord'(y), z: z, colour: col, last: last};
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Compare the output beat with the oldest predicted pixel.
    task automatic check_pixel;
        t_pixel w;
        if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel (%0d,%0d) with nothing expected",
                                      o_pixel_x, o_pixel_y));
            return;
        end
        w = pending_pixels.pop_front();
        pixels_checked++;
        if (w.last)
            ends_checked++;
        if (o_pixel_x !== w.x)
            report_mismatch($sformatf("pixel %0d x %0d, want %0d", pixels_checked,
                                      o_pixel_x, w.x));
        if (o_pixel_y !== w.y)
            report_mismatch($sformatf("pixel %0d y %0d, want %0d", pixels_checked,
                                      o_pixel_y, w.y));
        if (o_pixel_z !== w.z)
            report_mismatch($sformatf("pixel %0d z %h, want %h", pixels_checked,
                                      o_pixel_z, w.z));
        if (o_pixel_colour !== w.colour)
            report_mismatch($sformatf("pixel %0d colour %h, want %h", pixels_checked,
                                      o_pixel_colour, w.colour));
        if (o_last !== w.last)
            report_mismatch($sformatf("pixel %0d last %b, want %b", pixels_checked,
                                      o_last, w.last));
    endtask

    // Offer one beat, optionally after idle cycles, and predict at acceptance.
    task automatic send_beat(input t_beat b, input bit typed, input t_pixel want);
        t_pixel p;
        bit     got;
        if (idle_on) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_func    <= b.func;
        i_x_start <= b.xs;
        i_y_start <= b.ys;
        i_z_start <= b.zs;
        i_x_end   <= b.xe;
        i_y_end   <= b.ye;
        i_z_end   <= b.ze;
        i_colour  <= b.colour;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        got = rasterise_beat(b, p);
        if (typed) begin
            p   = want;
            got = 1'b1;
        end
        if (got)
            pending_pixels.push_back(p);
        if (b.func == FUNC_LOAD)
            lines_loaded++;
        else if (!got)
            idle_steps++;
        if (got || b.func == FUNC_LOAD)
            beats_counted++;
    endtask

    // Withdraw valid and wait for every predicted pixel to arrive.
    task automatic drain_pixels;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: check beats, then choose ready for the next edge.
    initial begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                check_pixel();
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Sender: reset, directed table, random lines, then the final drain.
    initial begin
        t_row   dir_table[$];
        t_beat  b;
        t_pixel none;
        int     dx, dy, len, n_steps, kind, off, long_lines;
        bit     broken, hold_done, pause_done;

        none       = '{x: '0, y: '0, z: '0, colour: '0, last: 1'b0};
        long_lines = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_func    <= FUNC_STEP;
        i_x_start <= '0;
        i_y_start <= '0;
        i_z_start <= '0;
        i_x_end   <= '0;
        i_y_end   <= '0;
        i_z_end   <= '0;
        i_colour  <= '0;
        idle_on   <= 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Step while idle, single point, swapped diagonal tie, horizontal line at the
        // left edge, steep line on the right edge, and a restart across the full range.
        dir_table.push_back(step_row(1'b0, 0, 0, '0, '0, 1'b0));
        dir_table.push_back(load_row(5, -3, 32'h7fff_ffff, 5, -3, 32'h0000_0001, 24'hffffff));
        dir_table.push_back(step_row(1'b1, 5, -3, 32'h7fff_ffff, 24'hffffff, 1'b1));
        dir_table.push_back(step_row(1'b0, 0, 0, '0, '0, 1'b0));
        dir_table.push_back(load_row(10, 0, 32'h1111_0000, 7, 3, 32'h8000_0000, 24'h000000));
        dir_table.push_back(step_row(1'b1, 7, 3, 32'h8000_0000, 24'h000000, 1'b0));
        dir_table.push_back(step_row(1'b0, 0, 0, '0, '0, 1'b0));
        dir_table.push_back(step_row(1'b0, 0, 0, '0, '0, 1'b0));
        dir_table.push_back(step_row(1'b1, 10, 0, 32'h8000_0000, 24'h000000, 1'b1));
        dir_table.push_back(load_row(-2048, 0, 32'h0, -2045, 0, 32'h7fff_ffff, 24'h123456));
        dir_table.push_back(step_row(1'b1, -2048, 0, 32'h0, 24'h123456, 1'b0));
        dir_table.push_back(step_row(1'b0, 0, 0, '0, '0, 1'b0));
        dir_table.push_back(step_row(1'b0, 0, 0, '0, '0, 1'b0));
        dir_table.push_back(step_row(1'b1, -2045, 0, 32'h0, 24'h123456, 1'b1));
        dir_table.push_back(load_row(2047, 2047, 32'h0001_0000, 2047, -2048, 32'hffff_0000,
                                     24'hff00ff));
        dir_table.push_back(step_row(1'b1, 2047, 2047, 32'h0001_0000, 24'hff00ff, 1'b0));
        dir_table.push_back(step_row(1'b0, 0, 0, '0, '0, 1'b0));
        dir_table.push_back(load_row(2047, 2047, 32'h0001_0000, -2048, -2048, 32'h8000_0000,
                                     24'haaaaaa));
        dir_table.push_back(step_row(1'b1, -2048, -2048, 32'h8000_0000, 24'haaaaaa, 1'b0));
        dir_table.push_back(step_row(1'b0, 0, 0, '0, '0, 1'b0));
        foreach (dir_table[i])
            send_beat(dir_table[i].beat, dir_table[i].typed, dir_table[i].want);

        // Random lines: mostly short complete walks, some overrun into idle steps,
        // some cut short by the next load, a few long and a few wild endpoints.
        beats_counted = 0;
        while (beats_counted < RANDOM_BEATS) begin
            if (!hold_done && beats_counted >= 120) begin
                hold_asked <= hold_asked + 1;
                hold_done = 1'b1;
            end
            if (!pause_done && beats_counted >= 300) begin
                drain_pixels();
                pause_done = 1'b1;
            end
            idle_on <= !(beats_counted >= 180 && beats_counted < 250);

            b      = random_beat(FUNC_LOAD);
            kind   = $urandom_range(99);
            broken = (kind < 10);
            if (!broken) begin
                if (kind < 13 && long_lines < 2) begin
                    long_lines++;
                    off  = $urandom_range(0, 600);
                    b.xe = clamp_coord(b.xs + off - 300);
                    off  = $urandom_range(0, 600);
                    b.ye = clamp_coord(b.ys + off - 300);
                end else begin
                    off  = $urandom_range(0, 24);
                    b.xe = clamp_coord(b.xs + off - 12);
                    off  = $urandom_range(0, 24);
                    b.ye = clamp_coord(b.ys + off - 12);
                end
            end
            dx  = b.xe - b.xs;
            dy  = b.ye - b.ys;
            dx  = (dx < 0) ? -dx : dx;
            dy  = (dy < 0) ? -dy : dy;
            len = ((dx > dy) ? dx : dy) + 1;

            if (broken) begin
                n_steps = $urandom_range(0, 8);
            end else begin
                kind = $urandom_range(99);
                if (kind < 75)
                    n_steps = len;
                else if (kind < 88)
                    n_steps = len + $urandom_range(1, 3);
                else
                    n_steps = $urandom_range(0, len - 1);
            end

            send_beat(b, 1'b0, none);
            repeat (n_steps)
                send_beat(random_beat(FUNC_STEP), 1'b0, none);
        end

        drain_pixels();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d line loads, %0d pixels checked, %0d line ends,",
                 lines_loaded, pixels_checked, ends_checked);
        $display("%0d steps while idle, one long output hold-off and one full drain.",
                 idle_steps);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- line_pixel_generator.f -----
sv/lpg_pkg.sv
sv/lpg_setup.sv
sv/lpg_walker.sv
sv/line_pixel_generator.sv
sv/lpg_checker.sv
dv/testbench.sv
